[hdl/wlc_pkg.sv]
// ----------------------------------------------------------------------------
// wlc_pkg: shared types and constants for the weighted least-connections
// selector. It holds the field widths, the queue depth and the entry record
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package wlc_pkg;

  // Backend list and field widths
  localparam int MAX_BACKENDS = 256;
  localparam int IDX_BITS     = $clog2(MAX_BACKENDS);
  localparam int COUNT_BITS   = 20;
  localparam int WM1_BITS     = 8;
  localparam int WEIGHT_BITS  = WM1_BITS + 1;
  localparam int PROD_BITS    = COUNT_BITS + WEIGHT_BITS;

  // Front-to-back queue; the depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [PROD_BITS-1:0]   prod_t;

  // One classified backend entry
  typedef struct packed {
    count_t  conn;
    weight_t weight;
    idx_t    pos;
    logic    skip;
    logic    last;
  } entry_t;

endpackage

[hdl/weighted_least_conn_select_unit.sv]
// ----------------------------------------------------------------------------
// weighted_least_conn_select_unit: weighted least-connections selector.
// Streams backend entries, picks the untried entry with the lowest
// connections per unit of weight, and reports its list position.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   input   | in        | in_valid/in_ready  | open_conns, weight_minus_one,
//           |           |                    | skip, last_entry
//   output  | out       | out_valid/out_ready| chosen_index, found
//
// One entry per cycle is sustained while the queue has room; the
// running-best compare (two 20x9 multiplies and a compare) sets that rate.
// The result of a list is registered when its last entry leaves the queue.
// Reset clears the queue, the position counter and the running best.
// A four-entry queue parts the input from the compare; in_ready drops only
// when it is full, which happens when results are not taken.
// ----------------------------------------------------------------------------
module weighted_least_conn_select_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wlc_pkg::COUNT_BITS-1:0]  open_conns,
  input  logic [wlc_pkg::WM1_BITS-1:0]    weight_minus_one,
  input  logic                            skip,
  input  logic                            last_entry,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wlc_pkg::IDX_BITS-1:0]    chosen_index,
  output logic                            found
);

  logic            push;
  wlc_pkg::entry_t push_entry;
  logic            queue_full;
  logic            pop;
  logic            head_valid;
  wlc_pkg::entry_t head_entry;

  wlc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .open_conns       (open_conns),
    .weight_minus_one (weight_minus_one),
    .skip             (skip),
    .last_entry       (last_entry),
    .push             (push),
    .push_entry       (push_entry),
    .queue_full       (queue_full)
  );

  wlc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  wlc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chosen_index (chosen_index),
    .found        (found)
  );

endmodule

[hdl/wlc_front.sv]
// ----------------------------------------------------------------------------
// wlc_front: input stage of the selector.
// Accepts backend entries, tags each with its list position, forms the
// effective weight and pushes the record into the queue.
// ----------------------------------------------------------------------------
module wlc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wlc_pkg::COUNT_BITS-1:0]      open_conns,
  input  logic [wlc_pkg::WM1_BITS-1:0]        weight_minus_one,
  input  logic                                skip,
  input  logic                                last_entry,
  output logic                                push,
  output wlc_pkg::entry_t                     push_entry,
  input  logic                                queue_full
);

  wlc_pkg::idx_t position;
  wlc_pkg::idx_t position_next;

  // Take a beat whenever the queue has room
  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // Build the entry record
  always_comb begin
    push_entry.conn   = open_conns;
    push_entry.weight = {1'b0, weight_minus_one} + wlc_pkg::WEIGHT_BITS'(1);
    push_entry.pos    = position;
    push_entry.skip   = skip;
    push_entry.last   = last_entry;
  end

  // Advance the position, wrap to zero after the last entry of a list
  always_comb begin
    position_next = position;
    if (push) begin
      if (last_entry) begin
        position_next = '0;
      end else begin
        position_next = position + wlc_pkg::IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else begin
      position <= position_next;
    end
  end

endmodule

[hdl/wlc_queue.sv]
// ----------------------------------------------------------------------------
// wlc_queue: short FIFO between front and back end.
// Holds classified entries so that either side can stall on its own.
// ----------------------------------------------------------------------------
module wlc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wlc_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output wlc_pkg::entry_t head_entry
);

  wlc_pkg::entry_t                    slots [wlc_pkg::QUEUE_DEPTH];
  logic [wlc_pkg::QPTR_BITS-1:0]      wr_ptr;
  logic [wlc_pkg::QPTR_BITS-1:0]      rd_ptr;
  logic [wlc_pkg::QCNT_BITS-1:0]      count;

  assign full       = (count == wlc_pkg::QCNT_BITS'(wlc_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + wlc_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wlc_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + wlc_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - wlc_pkg::QCNT_BITS'(1);
      end
    end
  end

  // Occupancy stays within the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= wlc_pkg::QCNT_BITS'(wlc_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // Pointer distance matches the occupancy
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    wlc_pkg::QPTR_BITS'(count) == wlc_pkg::QPTR_BITS'(wr_ptr - rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

[hdl/wlc_back.sv]
// ----------------------------------------------------------------------------
// wlc_back: selection stage of the selector.
// Pops entries, keeps the running best by a cross-multiplied ratio compare
// and loads the result register on the last entry of each list.
// ----------------------------------------------------------------------------
module wlc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  wlc_pkg::entry_t              head_entry,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wlc_pkg::IDX_BITS-1:0] chosen_index,
  output logic                         found
);

  wlc_pkg::idx_t    best_index;
  wlc_pkg::count_t  best_count;
  wlc_pkg::weight_t best_weight;
  logic             have_best;

  wlc_pkg::prod_t   lhs;
  wlc_pkg::prod_t   rhs;
  logic             win;
  logic             res_found;
  wlc_pkg::idx_t    res_index;

  // Hold a last entry while an earlier result still waits
  assign pop = head_valid && (!head_entry.last || !out_valid || out_ready);

  // Cross-multiplied compare of connections per unit of weight
  always_comb begin
    lhs = wlc_pkg::PROD_BITS'(head_entry.conn) * wlc_pkg::PROD_BITS'(best_weight);
    rhs = wlc_pkg::PROD_BITS'(best_count) * wlc_pkg::PROD_BITS'(head_entry.weight);
    win = !head_entry.skip && (lhs < rhs);
  end

  // Result of a list that ends with this entry
  always_comb begin
    res_found = win || have_best;
    if (win) begin
      res_index = head_entry.pos;
    end else if (have_best) begin
      res_index = best_index;
    end else begin
      res_index = '0;
    end
  end

  // Update the running best, drop it after the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      best_index  <= '0;
      best_count  <= wlc_pkg::COUNT_BITS'(1);
      best_weight <= '0;
      have_best   <= 1'b0;
    end else if (pop) begin
      if (head_entry.last) begin
        best_index  <= '0;
        best_count  <= wlc_pkg::COUNT_BITS'(1);
        best_weight <= '0;
        have_best   <= 1'b0;
      end else if (win) begin
        best_index  <= head_entry.pos;
        best_count  <= head_entry.conn;
        best_weight <= head_entry.weight;
        have_best   <= 1'b1;
      end
    end
  end

  // Output register: load on the last entry, clear when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_entry.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_entry.last) begin
      chosen_index <= res_index;
      found        <= res_found;
    end
  end

  // A finished list leaves the running best at its starting values
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    pop && head_entry.last |=> !have_best && best_weight == '0)
    else $error("running best not cleared after last entry");

  // An empty selection reports index zero
  a_not_found_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> chosen_index == '0)
    else $error("index nonzero with nothing found");

  // Once some entry has won, the best weight is nonzero
  a_best_weight: assert property (@(posedge clk) disable iff (rst)
    have_best |-> best_weight != '0)
    else $error("running best has zero weight");

  // A last entry never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(pop && head_entry.last))
    else $error("pending result overwritten");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for weighted_least_conn_select_unit
// Streams backend lists into the selector and keeps its own running-best
// ranking beside it. Every list that closes with a last entry queues one
// expected pick, and each beat on the output side is checked against the
// oldest pick. A short table of hand-picked lists comes first. Random lists
// follow: mostly short ones with mixed skip rates, ties and extreme counts,
// and at most two lists long enough to wrap the position counter. Both sides
// stall in random bursts, except in the last stretch of the run.
// ----------------------------------------------------------------------------
module tb_top;

  // Expected outcome of one backend list
  typedef struct {
    wlc_pkg::idx_t index;
    logic          found;
  } pick_t;

  // One row of the directed table; typed rows carry a hand-written pick
  typedef struct packed {
    wlc_pkg::count_t              conn;
    logic [wlc_pkg::WM1_BITS-1:0] wm1;
    logic                         sk;
    logic                         lst;
    logic                         typed;
    wlc_pkg::idx_t                exp_index;
    logic                         exp_found;
  } probe_row_t;

  localparam int NUM_PROBES = 18;
  localparam wlc_pkg::count_t CONN_MAX = '1;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  wlc_pkg::count_t              open_conns;
  logic [wlc_pkg::WM1_BITS-1:0] weight_minus_one;
  logic                         skip;
  logic                         last_entry;
  logic                         out_valid;
  logic                         out_ready;
  wlc_pkg::idx_t                chosen_index;
  logic                         found;

  // Predictor state: running best of the list in progress
  wlc_pkg::idx_t    run_pos;
  wlc_pkg::idx_t    lead_index;
  wlc_pkg::count_t  lead_conn;
  wlc_pkg::weight_t lead_weight;
  logic             lead_valid;

  pick_t pending_picks[$];
  int    error_count;
  logic  idle_on;
  int    stall_left = 0;

  probe_row_t probes [0:NUM_PROBES-1] = '{
    // lone entry with the largest count and weight
    '{CONN_MAX,  8'd255, 1'b0, 1'b1, 1'b1, 8'd0, 1'b1},
    // lone entry, already tried
    '{20'd0,     8'd0,   1'b1, 1'b1, 1'b1, 8'd0, 1'b0},
    // zero connections on the leader cannot be beaten
    '{20'd0,     8'd0,   1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{20'd5,     8'd255, 1'b0, 1'b1, 1'b1, 8'd0, 1'b1},
    // equal ratios keep the earlier entry
    '{20'd10,    8'd1,   1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{20'd5,     8'd0,   1'b0, 1'b1, 1'b1, 8'd0, 1'b1},
    // heavier weight wins, a tried entry is passed over
    '{20'd100,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{20'd100,   8'd1,   1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{20'd0,     8'd255, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0},
    '{CONN_MAX,  8'd0,   1'b0, 1'b1, 1'b1, 8'd1, 1'b1},
    // every entry tried
    '{20'd0,     8'd0,   1'b1, 1'b0, 1'b0, 8'd0, 1'b0},
    '{CONN_MAX,  8'd255, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0},
    // first entry tried, the worst untried one still wins
    '{20'd0,     8'd255, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0},
    '{CONN_MAX,  8'd0,   1'b0, 1'b1, 1'b1, 8'd1, 1'b1},
    // steadily better entries
    '{CONN_MAX,  8'd0,   1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{CONN_MAX,  8'd255, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0},
    '{20'd1,     8'd0,   1'b0, 1'b1, 1'b1, 8'd2, 1'b1},
    // alternating bit patterns
    '{20'hAAAAA, 8'h55,  1'b0, 1'b0, 1'b0, 8'd0, 1'b0}
  };

  weighted_least_conn_select_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .open_conns       (open_conns),
    .weight_minus_one (weight_minus_one),
    .skip             (skip),
    .last_entry       (last_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .chosen_index     (chosen_index),
    .found            (found)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop the running best back to its reset values
  function automatic void clear_ranking();
    run_pos     = '0;
    lead_index  = '0;
    lead_conn   = wlc_pkg::count_t'(1);
    lead_weight = '0;
    lead_valid  = 1'b0;
  endfunction

  // Rank one entry against the leader; return 1 when the list closes
  function automatic bit rank_entry(input wlc_pkg::count_t c,
                                    input logic [wlc_pkg::WM1_BITS-1:0] wm1,
                                    input logic sk, input logic lst,
                                    output pick_t pick);
    wlc_pkg::weight_t w;
    wlc_pkg::prod_t   lhs;
    wlc_pkg::prod_t   rhs;
    w    = wlc_pkg::weight_t'(wm1) + wlc_pkg::weight_t'(1);
    lhs  = wlc_pkg::prod_t'(c) * wlc_pkg::prod_t'(lead_weight);
    rhs  = wlc_pkg::prod_t'(lead_conn) * wlc_pkg::prod_t'(w);
    pick = '{index: '0, found: 1'b0};
    if (!sk && lhs < rhs) begin
      lead_index  = run_pos;
      lead_conn   = c;
      lead_weight = w;
      lead_valid  = 1'b1;
    end
    run_pos = run_pos + wlc_pkg::idx_t'(1);
    if (!lst)
      return 1'b0;
    pick.index = lead_valid ? lead_index : '0;
    pick.found = lead_valid;
    clear_ranking();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR @%0t: %s got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // Present one entry, hold it until accepted, then rank it; a last entry queues its list's pick
  task automatic push_entry(input wlc_pkg::count_t c,
                            input logic [wlc_pkg::WM1_BITS-1:0] wm1,
                            input logic sk, input logic lst, input logic typed,
                            input wlc_pkg::idx_t t_index, input logic t_found);
    pick_t pick;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    open_conns       <= c;
    weight_minus_one <= wm1;
    skip             <= sk;
    last_entry       <= lst;
    do @(posedge clk); while (!in_ready);
    if (rank_entry(c, wm1, sk, lst, pick)) begin
      if (typed)
        pick = '{index: t_index, found: t_found};
      pending_picks.push_back(pick);
    end
  endtask

  // Output side: check each beat, stall in random bursts
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_picks.size() == 0) begin
        report_mismatch("unexpected result, chosen_index", chosen_index, -1);
      end else begin
        if (chosen_index !== pending_picks[0].index)
          report_mismatch("chosen_index", chosen_index, pending_picks[0].index);
        if (found !== pending_picks[0].found)
          report_mismatch("found", found, pending_picks[0].found);
        void'(pending_picks.pop_front());
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stimulus
  initial begin
    int                           sent;
    int                           len;
    int                           long_lists;
    int                           skip_pct;
    int                           conn_mode;
    int                           wm_mode;
    wlc_pkg::count_t              c;
    logic [wlc_pkg::WM1_BITS-1:0] wm1;

    sent        = 0;
    long_lists  = 0;
    error_count = 0;
    clear_ranking();
    rst              <= 1'b1;
    idle_on          <= 1'b0;
    in_valid         <= 1'b0;
    open_conns       <= '0;
    weight_minus_one <= '0;
    skip             <= 1'b0;
    last_entry       <= 1'b0;
    out_ready        <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table; the alternating row closes with a checked last entry
    idle_on <= 1'b1;
    foreach (probes[i])
      push_entry(probes[i].conn, probes[i].wm1, probes[i].sk, probes[i].lst,
                 probes[i].typed, probes[i].exp_index, probes[i].exp_found);
    push_entry(20'h55555, 8'hAA, 1'b0, 1'b1, 1'b0, '0, 1'b0);
    sent = NUM_PROBES + 1;

    // Random lists
    while (sent < 1500) begin
      if (sent > 1300)
        idle_on <= 1'b0;
      else
        idle_on <= ($urandom_range(0, 3) != 0);
      if (long_lists < 2 && sent < 900 && $urandom_range(0, 99) >= 96) begin
        len = $urandom_range(257, 600);
        long_lists++;
      end else if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 16);
      end else begin
        len = $urandom_range(17, 64);
      end
      case ($urandom_range(0, 4))
        0:       skip_pct = 0;
        1:       skip_pct = 100;
        2:       skip_pct = 70;
        default: skip_pct = 25;
      endcase
      conn_mode = $urandom_range(0, 3);
      wm_mode   = $urandom_range(0, 2);
      for (int k = 0; k < len; k++) begin
        case (conn_mode)
          0:       c = wlc_pkg::count_t'($urandom_range(0, 7));
          1:       c = wlc_pkg::count_t'($urandom_range(0, 255));
          2:       c = ($urandom_range(0, 1) != 0) ? CONN_MAX : '0;
          default: c = wlc_pkg::count_t'($urandom);
        endcase
        case (wm_mode)
          0:       wm1 = wlc_pkg::WM1_BITS'($urandom_range(0, 3));
          1:       wm1 = ($urandom_range(0, 1) != 0) ? '1 : '0;
          default: wm1 = wlc_pkg::WM1_BITS'($urandom);
        endcase
        push_entry(c, wm1, ($urandom_range(0, 99) < skip_pct), (k == len - 1),
                   1'b0, '0, 1'b0);
      end
      sent += len;
    end
    in_valid <= 1'b0;
    idle_on  <= 1'b0;

    // Drain, then wait for stray results
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
